FILE: hw/rtl/e2r_pkg.sv
// Shared types and constants for the Euler-angle to rotation matrix unit.
// Used by e2r_cordic, e2r_matrix and the top level; depends on nothing.
`default_nettype none

package e2r_pkg;

	// Internal angle / CORDIC word: signed Q3.30 held in 34 bits
	localparam int ZW = 34;
	// Sine and cosine after the CORDIC: signed Q1.30 held in 32 bits
	localparam int TW = 32;
	// Full product of two trig words
	localparam int PW = 2 * TW;
	// Matrix sums before output scaling
	localparam int SW = TW + 1;

	localparam int CORDIC_STEPS = 24;

	localparam logic signed [ZW-1:0] PI_Q30      = 34'sd3373259426;
	localparam logic signed [ZW-1:0] HALF_PI_Q30 = 34'sd1686629713;
	localparam logic signed [ZW-1:0] CORDIC_K    = 34'sh026DD3B6A;

	// atan(2^-i) in Q30, truncated
	localparam logic signed [ZW-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
		34'sh03243F6A8, 34'sh01DAC6705, 34'sh00FADBAFC, 34'sh007F56EA6,
		34'sh003FEAB76, 34'sh001FFD55B, 34'sh000FFFAAA, 34'sh0007FFF55,
		34'sh0003FFFEA, 34'sh0001FFFFD, 34'sh0000FFFFF, 34'sh00007FFFF,
		34'sh00003FFFF, 34'sh00001FFFF, 34'sh00000FFFF, 34'sh000007FFF,
		34'sh000003FFF, 34'sh000001FFF, 34'sh000000FFF, 34'sh0000007FF,
		34'sh0000003FF, 34'sh0000001FF, 34'sh0000000FF, 34'sh00000007F
	};

	typedef struct packed {
		logic signed [TW-1:0] s;
		logic signed [TW-1:0] c;
	} sincos_t;

	// Q30 x Q30 product back to Q30, rounded half up
	function automatic logic signed [TW-1:0] rnd_q30(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] t;
		t = (p + 64'sd536870912) >>> 30;
		return t[TW-1:0];
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/e2r_cordic.sv
// Pipelined rotation-mode CORDIC: one angle in, its sine and cosine out.
// Quadrant fold, one stage per CORDIC step, sign restore. Uses e2r_pkg.
`default_nettype none

module e2r_cordic import e2r_pkg::*; #(
	parameter int ANGLE_WIDTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  wire logic [ANGLE_WIDTH-1:0]  angle,
	output logic                         out_valid,
	output sincos_t                      sc
);

	logic signed [ZW-1:0] z_in;
	logic signed [ZW-1:0] z_fold;
	logic                 flip_in;

	logic signed [ZW-1:0] x_s    [CORDIC_STEPS+1];
	logic signed [ZW-1:0] y_s    [CORDIC_STEPS+1];
	logic signed [ZW-1:0] z_s    [CORDIC_STEPS];
	logic                 flip_s [CORDIC_STEPS+1];
	logic                 v_s    [CORDIC_STEPS+1];

	logic signed [ZW-1:0] sin_neg;
	logic signed [ZW-1:0] cos_neg;

	// Q2.(ANGLE_WIDTH-3) to Q3.30
	assign z_in = $signed({{(ZW-ANGLE_WIDTH){angle[ANGLE_WIDTH-1]}}, angle})
		<<< (33 - ANGLE_WIDTH);

	// Fold into -pi/2..pi/2; the flip negates both results at the end
	always_comb begin
		priority if (z_in > HALF_PI_Q30) begin
			z_fold  = z_in - PI_Q30;
			flip_in = 1'b1;
		end else if (z_in < -HALF_PI_Q30) begin
			z_fold  = z_in + PI_Q30;
			flip_in = 1'b1;
		end else begin
			z_fold  = z_in;
			flip_in = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		x_s[0]    <= CORDIC_K;
		y_s[0]    <= '0;
		z_s[0]    <= z_fold;
		flip_s[0] <= flip_in;
		for (int k = 0; k < CORDIC_STEPS; k++) begin
			flip_s[k+1] <= flip_s[k];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= CORDIC_STEPS; k++) begin
				v_s[k] <= 1'b0;
			end
			out_valid <= 1'b0;
		end else begin
			v_s[0] <= in_valid;
			for (int k = 0; k < CORDIC_STEPS; k++) begin
				v_s[k+1] <= v_s[k];
			end
			out_valid <= v_s[CORDIC_STEPS];
		end
	end

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		always_ff @(posedge clk) begin
			if (z_s[i][ZW-1]) begin
				x_s[i+1] <= x_s[i] + (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] - (x_s[i] >>> i);
			end else begin
				x_s[i+1] <= x_s[i] - (y_s[i] >>> i);
				y_s[i+1] <= y_s[i] + (x_s[i] >>> i);
			end
		end

		// The last step's residual angle is never used
		if (i < CORDIC_STEPS - 1) begin : g_z
			always_ff @(posedge clk) begin
				if (z_s[i][ZW-1]) begin
					z_s[i+1] <= z_s[i] + ATAN_Q30[i];
				end else begin
					z_s[i+1] <= z_s[i] - ATAN_Q30[i];
				end
			end
		end
	end

	assign sin_neg = -y_s[CORDIC_STEPS];
	assign cos_neg = -x_s[CORDIC_STEPS];

	// Results stay within about one in Q30, so 32 bits hold them
	always_ff @(posedge clk) begin
		if (flip_s[CORDIC_STEPS]) begin
			sc.s <= sin_neg[TW-1:0];
			sc.c <= cos_neg[TW-1:0];
		end else begin
			sc.s <= y_s[CORDIC_STEPS][TW-1:0];
			sc.c <= x_s[CORDIC_STEPS][TW-1:0];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/e2r_matrix.sv
// Product and sum pipeline that builds the transposed ZYX rotation matrix
// from three sine/cosine pairs, then rounds and saturates it. Uses e2r_pkg.
`default_nettype none

module e2r_matrix import e2r_pkg::*; #(
	parameter int OUT_WIDTH = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          in_valid,
	input  sincos_t                      sc_r,
	input  sincos_t                      sc_p,
	input  sincos_t                      sc_y,
	output logic                         out_valid,
	output logic signed [OUT_WIDTH-1:0]  m_s6 [9]
);

	localparam int SH = TW - OUT_WIDTH;
	localparam logic signed [SW:0] ONE_W = (SW+1)'(1);
	localparam logic signed [SW:0] RND_HALF = (SH > 0) ?
		(ONE_W <<< ((SH > 0) ? SH - 1 : 0)) : '0;
	localparam logic signed [SW:0] LIM = ONE_W <<< (OUT_WIDTH - 2);

	// First-level product slots
	localparam int T_CYCP = 0;
	localparam int T_SYCR = 1;
	localparam int T_SYSR = 2;
	localparam int T_SYCP = 3;
	localparam int T_CYCR = 4;
	localparam int T_CYSR = 5;
	localparam int T_CPSR = 6;
	localparam int T_CPCR = 7;

	// Second-level product slots
	localparam int Q_CYSPSR = 0;
	localparam int Q_SYSPSR = 1;
	localparam int Q_CYSPCR = 2;
	localparam int Q_SYSPCR = 3;

	logic signed [PW-1:0] p_s1 [8];
	logic signed [PW-1:0] spsr_s1;
	logic signed [PW-1:0] spcr_s1;
	logic signed [TW-1:0] cy_s1, sy_s1, sp_s1;

	logic signed [TW-1:0] t_s2 [8];
	logic signed [TW-1:0] spsr_s2, spcr_s2;
	logic signed [TW-1:0] cy_s2, sy_s2, sp_s2;

	logic signed [TW-1:0] t_s3 [8];
	logic signed [PW-1:0] q_s3 [4];
	logic signed [TW-1:0] sp_s3;

	logic signed [TW-1:0] t_s4 [8];
	logic signed [TW-1:0] q_s4 [4];
	logic signed [TW-1:0] sp_s4;

	logic signed [SW-1:0] sum_s5 [9];

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	// Q30 sum to Q1.(OUT_WIDTH-2), round half up, clamp to plus or minus one
	function automatic logic signed [OUT_WIDTH-1:0] to_out(input logic signed [SW-1:0] v);
		logic signed [SW:0] w;
		w = ((SW+1)'(v) + RND_HALF) >>> SH;
		if (w > LIM) begin
			w = LIM;
		end else if (w < -LIM) begin
			w = -LIM;
		end
		return w[OUT_WIDTH-1:0];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s4      <= 1'b0;
			v_s5      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s4      <= v_s3;
			v_s5      <= v_s4;
			out_valid <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		// Stage 1: all single products
		p_s1[T_CYCP] <= sc_y.c * sc_p.c;
		p_s1[T_SYCR] <= sc_y.s * sc_r.c;
		p_s1[T_SYSR] <= sc_y.s * sc_r.s;
		p_s1[T_SYCP] <= sc_y.s * sc_p.c;
		p_s1[T_CYCR] <= sc_y.c * sc_r.c;
		p_s1[T_CYSR] <= sc_y.c * sc_r.s;
		p_s1[T_CPSR] <= sc_p.c * sc_r.s;
		p_s1[T_CPCR] <= sc_p.c * sc_r.c;
		spsr_s1      <= sc_p.s * sc_r.s;
		spcr_s1      <= sc_p.s * sc_r.c;
		cy_s1        <= sc_y.c;
		sy_s1        <= sc_y.s;
		sp_s1        <= sc_p.s;

		// Stage 2: round to Q30
		for (int k = 0; k < 8; k++) begin
			t_s2[k] <= rnd_q30(p_s1[k]);
		end
		spsr_s2 <= rnd_q30(spsr_s1);
		spcr_s2 <= rnd_q30(spcr_s1);
		cy_s2   <= cy_s1;
		sy_s2   <= sy_s1;
		sp_s2   <= sp_s1;

		// Stage 3: yaw terms times the bracketed pitch-roll products
		q_s3[Q_CYSPSR] <= cy_s2 * spsr_s2;
		q_s3[Q_SYSPSR] <= sy_s2 * spsr_s2;
		q_s3[Q_CYSPCR] <= cy_s2 * spcr_s2;
		q_s3[Q_SYSPCR] <= sy_s2 * spcr_s2;
		t_s3           <= t_s2;
		sp_s3          <= sp_s2;

		// Stage 4: round the second-level products
		for (int k = 0; k < 4; k++) begin
			q_s4[k] <= rnd_q30(q_s3[k]);
		end
		t_s4  <= t_s3;
		sp_s4 <= sp_s3;

		// Stage 5: matrix entries
		sum_s5[0] <= SW'(t_s4[T_CYCP]);
		sum_s5[1] <= SW'(q_s4[Q_CYSPSR]) - SW'(t_s4[T_SYCR]);
		sum_s5[2] <= SW'(t_s4[T_SYSR]) + SW'(q_s4[Q_CYSPCR]);
		sum_s5[3] <= SW'(t_s4[T_SYCP]);
		sum_s5[4] <= SW'(t_s4[T_CYCR]) + SW'(q_s4[Q_SYSPSR]);
		sum_s5[5] <= SW'(q_s4[Q_SYSPCR]) - SW'(t_s4[T_CYSR]);
		sum_s5[6] <= -SW'(sp_s4);
		sum_s5[7] <= SW'(t_s4[T_CPSR]);
		sum_s5[8] <= SW'(t_s4[T_CPCR]);

		// Stage 6: scale and clamp
		for (int k = 0; k < 9; k++) begin
			m_s6[k] <= to_out(sum_s5[k]);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/euler_to_rotation_matrix_unit.sv
// Top level: roll/pitch/yaw to body-to-world rotation matrix (transposed ZYX DCM).
// Instantiates three e2r_cordic lanes and e2r_matrix; uses e2r_pkg.
//
//   channel   handshake        payload
//   command   start / busy     roll_angle, pitch_angle, yaw_angle (Q2.x radians)
//   result    done (strobe)    m00 .. m22 (Q1.x, clamped to plus or minus one)
//
// One transaction may start every cycle; its result strobes on done after the fold,
// the 24 CORDIC steps, the sign restore and the product/sum pipeline.
// busy stays low: the pipeline never holds, and results are not back-pressured.
// Reset clears only the valid bits; data registers load freely.
`default_nettype none

module euler_to_rotation_matrix_unit import e2r_pkg::*; #(
	parameter int ANGLE_WIDTH = 16,
	parameter int OUT_WIDTH   = 16
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  wire logic [ANGLE_WIDTH-1:0]  roll_angle,
	input  wire logic [ANGLE_WIDTH-1:0]  pitch_angle,
	input  wire logic [ANGLE_WIDTH-1:0]  yaw_angle,
	output logic                         done,
	output logic signed [OUT_WIDTH-1:0]  m00,
	output logic signed [OUT_WIDTH-1:0]  m01,
	output logic signed [OUT_WIDTH-1:0]  m02,
	output logic signed [OUT_WIDTH-1:0]  m10,
	output logic signed [OUT_WIDTH-1:0]  m11,
	output logic signed [OUT_WIDTH-1:0]  m12,
	output logic signed [OUT_WIDTH-1:0]  m20,
	output logic signed [OUT_WIDTH-1:0]  m21,
	output logic signed [OUT_WIDTH-1:0]  m22
);

	logic    accept;
	logic    r_valid, p_valid, y_valid;
	sincos_t sc_r, sc_p, sc_y;
	logic signed [OUT_WIDTH-1:0] m [9];

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.angle     (roll_angle),
		.out_valid (r_valid),
		.sc        (sc_r)
	);

	e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.angle     (pitch_angle),
		.out_valid (p_valid),
		.sc        (sc_p)
	);

	e2r_cordic #(.ANGLE_WIDTH(ANGLE_WIDTH)) u_cordic_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.angle     (yaw_angle),
		.out_valid (y_valid),
		.sc        (sc_y)
	);

	e2r_matrix #(.OUT_WIDTH(OUT_WIDTH)) u_matrix (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (r_valid & p_valid & y_valid),
		.sc_r      (sc_r),
		.sc_p      (sc_p),
		.sc_y      (sc_y),
		.out_valid (done),
		.m_s6      (m)
	);

	assign m00 = m[0];
	assign m01 = m[1];
	assign m02 = m[2];
	assign m10 = m[3];
	assign m11 = m[4];
	assign m12 = m[5];
	assign m20 = m[6];
	assign m21 = m[7];
	assign m22 = m[8];

endmodule

`default_nettype wire

FILE: sim/e2r_checker.sv
// Scoreboard for euler_to_rotation_matrix_unit: predicts the rotation matrix of each
// accepted angle triple and compares it with the matrix on the result strobe.
// Self-contained; depends on no RTL file or package.

module e2r_checker #(
	parameter int ANGLE_WIDTH = 16,
	parameter int OUT_WIDTH   = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic                         busy,
	input  logic [ANGLE_WIDTH-1:0]       roll_angle,
	input  logic [ANGLE_WIDTH-1:0]       pitch_angle,
	input  logic [ANGLE_WIDTH-1:0]       yaw_angle,
	input  logic                         done,
	input  logic signed [OUT_WIDTH-1:0]  m00,
	input  logic signed [OUT_WIDTH-1:0]  m01,
	input  logic signed [OUT_WIDTH-1:0]  m02,
	input  logic signed [OUT_WIDTH-1:0]  m10,
	input  logic signed [OUT_WIDTH-1:0]  m11,
	input  logic signed [OUT_WIDTH-1:0]  m12,
	input  logic signed [OUT_WIDTH-1:0]  m20,
	input  logic signed [OUT_WIDTH-1:0]  m21,
	input  logic signed [OUT_WIDTH-1:0]  m22,
	output int                           mismatches,
	output int                           pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int     N_STEPS   = 24;
	localparam longint PI_Z      = 64'sd3373259426;
	localparam longint HALF_PI_Z = 64'sd1686629713;
	localparam longint GAIN_INV  = 64'sh26DD3B6A;
	localparam longint ROUND_Z   = 64'sd536870912;

	// Entry k holds row k/3, column k%3
	typedef logic [8:0][OUT_WIDTH-1:0] dcm_t;

	longint atan_lut [N_STEPS];
	dcm_t   dcm_q [$];

	initial begin
		atan_lut = '{
			64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6,
			64'h03FEAB76, 64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55,
			64'h003FFFEA, 64'h001FFFFD, 64'h000FFFFF, 64'h0007FFFF,
			64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF, 64'h00007FFF,
			64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
			64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F
		};
		mismatches = 0;
		pending = 0;
	end

	function automatic void cordic_sincos(input logic [ANGLE_WIDTH-1:0] raw,
			output longint s, output longint c);
		longint x, y, z, dx, dy;
		bit     flip;
		z = longint'($signed(raw)) * (longint'(1) << (33 - ANGLE_WIDTH));
		flip = 1'b0;
		// fold into -pi/2..pi/2 and negate the results afterwards
		if (z > HALF_PI_Z) begin
			z = z - PI_Z;
			flip = 1'b1;
		end else if (z < -HALF_PI_Z) begin
			z = z + PI_Z;
			flip = 1'b1;
		end
		x = GAIN_INV;
		y = 0;
		for (int i = 0; i < N_STEPS; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x = x - dx;
				y = y + dy;
				z = z - atan_lut[i];
			end else begin
				x = x + dx;
				y = y - dy;
				z = z + atan_lut[i];
			end
		end
		s = flip ? -y : y;
		c = flip ? -x : x;
	endfunction

	function automatic longint qmul(input longint a, input longint b);
		return (a * b + ROUND_Z) >>> 30;
	endfunction

	// Round Q30 half up to the output grid and clamp to plus or minus one
	function automatic logic [OUT_WIDTH-1:0] to_entry(input longint v);
		longint lim;
		longint r;
		lim = longint'(1) << (OUT_WIDTH - 2);
		r = v;
		if (OUT_WIDTH < 32)
			r = (r + (longint'(1) << (31 - OUT_WIDTH))) >>> (32 - OUT_WIDTH);
		if (r > lim)
			r = lim;
		if (r < -lim)
			r = -lim;
		return r[OUT_WIDTH-1:0];
	endfunction

	function automatic dcm_t predict_dcm(input logic [ANGLE_WIDTH-1:0] r,
			input logic [ANGLE_WIDTH-1:0] p, input logic [ANGLE_WIDTH-1:0] y);
		longint sr, cr, sp, cp, sy, cy, spsr, spcr;
		dcm_t   d;
		cordic_sincos(r, sr, cr);
		cordic_sincos(p, sp, cp);
		cordic_sincos(y, sy, cy);
		spsr = qmul(sp, sr);
		spcr = qmul(sp, cr);
		d[0] = to_entry(qmul(cy, cp));
		d[1] = to_entry(-qmul(sy, cr) + qmul(cy, spsr));
		d[2] = to_entry(qmul(sy, sr) + qmul(cy, spcr));
		d[3] = to_entry(qmul(sy, cp));
		d[4] = to_entry(qmul(cy, cr) + qmul(sy, spsr));
		d[5] = to_entry(-qmul(cy, sr) + qmul(sy, spcr));
		d[6] = to_entry(-sp);
		d[7] = to_entry(qmul(cp, sr));
		d[8] = to_entry(qmul(cp, cr));
		return d;
	endfunction

	always @(posedge clk) begin
		dcm_t got;
		dcm_t want;
		if (arst_n) begin
			if (done) begin
				got = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
				if (dcm_q.size() == 0) begin
					$display("%0t: result with no transaction outstanding", $time);
					mismatches = mismatches + 1;
				end else begin
					want = dcm_q.pop_front();
					for (int k = 0; k < 9; k++) begin
						if (got[k] !== want[k]) begin
							$display("%0t: m%0d%0d expected %0d, actual %0d", $time,
								k / 3, k % 3, $signed(want[k]), $signed(got[k]));
							mismatches = mismatches + 1;
						end
					end
				end
			end
			if (start && !busy)
				dcm_q.push_back(predict_dcm(roll_angle, pitch_angle, yaw_angle));
			pending = dcm_q.size();
		end
	end

endmodule

FILE: sim/euler_to_rotation_matrix_unit_tb.sv
// Testbench top for euler_to_rotation_matrix_unit: drives angle triples back to back and
// with random gaps, and gives the verdict. Needs the unit's RTL and sim/e2r_checker.sv.

module euler_to_rotation_matrix_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int AW          = 16;
	localparam int OW          = 16;
	localparam int N_RANDOM    = 680;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN       = 40;
	// pi and pi/2 in Q2.13
	localparam int PI_RAW      = 25736;
	localparam int HALF_PI_RAW = 12868;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [AW-1:0]        roll_angle;
	logic [AW-1:0]        pitch_angle;
	logic [AW-1:0]        yaw_angle;
	logic                 done;
	logic signed [OW-1:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
	int                   mismatches;
	int                   pending;
	int                   stall_cnt;
	bit                   idle_on;

	euler_to_rotation_matrix_unit #(
		.ANGLE_WIDTH(AW),
		.OUT_WIDTH(OW)
	) u_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.done(done),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22)
	);

	e2r_checker #(
		.ANGLE_WIDTH(AW),
		.OUT_WIDTH(OW)
	) u_checker (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.roll_angle(roll_angle), .pitch_angle(pitch_angle), .yaw_angle(yaw_angle),
		.done(done),
		.m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
		.m20(m20), .m21(m21), .m22(m22),
		.mismatches(mismatches), .pending(pending)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// End the run if neither channel moves for too long
	always @(posedge clk) begin
		if (start && !busy || done)
			stall_cnt <= 0;
		else if (stall_cnt >= STALL_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end else
			stall_cnt <= stall_cnt + 1;
	end

	function automatic logic [AW-1:0] pick_angle();
		int sel;
		int sgn;
		sel = $urandom_range(0, 9);
		sgn = $urandom_range(0, 1) ? 1 : -1;
		case (sel)
			0, 1, 2, 3: return AW'($urandom);
			4, 5, 6:    return AW'(int'($urandom_range(0, 2 * PI_RAW)) - PI_RAW);
			7:          return AW'(sgn * (HALF_PI_RAW + int'($urandom_range(0, 8)) - 4));
			8:          return AW'(sgn * (PI_RAW + int'($urandom_range(0, 8)) - 4));
			default:    return AW'(int'($urandom_range(0, 32)) - 16);
		endcase
	endfunction

	task automatic send_angles(input logic [AW-1:0] r, input logic [AW-1:0] p,
			input logic [AW-1:0] y);
		int gap;
		gap = idle_on ? $urandom_range(0, 11) : 0;
		// drop start for the gap and scramble the idle payload
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			roll_angle <= AW'($urandom);
			pitch_angle <= AW'($urandom);
			yaw_angle <= AW'($urandom);
		end
		@(negedge clk);
		start <= 1'b1;
		roll_angle <= r;
		pitch_angle <= p;
		yaw_angle <= y;
		do @(posedge clk); while (busy);
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		roll_angle = '0;
		pitch_angle = '0;
		yaw_angle = '0;
		stall_cnt = 0;
		idle_on = 1'b0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// field extremes, folding boundaries and gimbal lock, back to back
		send_angles(16'sd0, 16'sd0, 16'sd0);
		send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
		send_angles(16'sh8000, 16'sh8000, 16'sh8000);
		send_angles(16'sh7FFF, 16'sh8000, 16'sd0);
		send_angles(16'sd1, -16'sd1, 16'sd1);
		send_angles(AW'(PI_RAW), AW'(PI_RAW), AW'(PI_RAW));
		send_angles(AW'(-PI_RAW), AW'(-PI_RAW), AW'(-PI_RAW));
		send_angles(AW'(HALF_PI_RAW), AW'(HALF_PI_RAW), AW'(HALF_PI_RAW));
		send_angles(AW'(HALF_PI_RAW - 1), AW'(HALF_PI_RAW - 1), AW'(HALF_PI_RAW - 1));
		send_angles(AW'(-HALF_PI_RAW), AW'(-HALF_PI_RAW), AW'(-HALF_PI_RAW));
		send_angles(AW'(-HALF_PI_RAW + 1), AW'(-HALF_PI_RAW + 1), AW'(-HALF_PI_RAW + 1));
		send_angles(16'sd0, AW'(HALF_PI_RAW), 16'sd0);
		send_angles(16'sd0, AW'(-HALF_PI_RAW), 16'sd0);
		send_angles(16'sd4000, AW'(HALF_PI_RAW - 1), -16'sd7000);
		send_angles(-16'sd9000, AW'(-HALF_PI_RAW + 1), 16'sd3000);
		send_angles(AW'(PI_RAW + 1), AW'(-PI_RAW - 1), 16'sd0);
		send_angles(16'sd6434, 16'sd6434, 16'sd6434);
		send_angles(-16'sd6434, 16'sd19302, -16'sd19302);
		send_angles(16'sh5555, 16'shAAAA, 16'sh5555);
		send_angles(16'shAAAA, 16'sh5555, 16'shAAAA);

		for (int n = 0; n < N_RANDOM; n++) begin
			// switch between gapped and back-to-back stretches
			if (n % 40 == 0)
				idle_on = ($urandom_range(0, 3) != 0);
			send_angles(pick_angle(), pick_angle(), pick_angle());
		end
		@(negedge clk);
		start <= 1'b0;

		wait (pending == 0);
		repeat (DRAIN) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/e2r_pkg.sv
hw/rtl/e2r_cordic.sv
hw/rtl/e2r_matrix.sv
hw/rtl/euler_to_rotation_matrix_unit.sv
sim/e2r_checker.sv
sim/euler_to_rotation_matrix_unit_tb.sv
